[rtl/cst_pkg.sv]
`default_nettype none

package cst_pkg;

    localparam int SUBDIV_LEVELS = 2;
    localparam int SCALE         = 1 << SUBDIV_LEVELS;
    localparam int CW            = SUBDIV_LEVELS + 2;           // signed coordinate
    localparam int AW            = CW - 1;                      // coordinate magnitude
    localparam int TRI_W         = 8;
    localparam int CUBE_W        = TRI_W - 2 * SUBDIV_LEVELS;
    localparam int NUM_CUBE_TRIS = 12;
    localparam int NW            = $clog2(3 * SCALE * SCALE + 1); // squared length
    localparam int GFRAC         = 24;
    localparam int GW            = GFRAC + 1;                   // 1/sqrt(n) scaled
    localparam int RW            = 16;
    localparam int OW            = 17;
    localparam int MW            = 17;
    localparam int FW            = 10;
    localparam int PW            = RW + GW;
    localparam int TW            = PW + AW;
    localparam int R2W           = 2 * RW;
    localparam int LW            = R2W + 2 * AW + 2;
    localparam int SQW           = 2 * (MW + 1);
    localparam int PRW           = SQW + NW;
    localparam int CMPW          = (PRW > LW) ? PRW : LW;
    localparam int LAT           = SUBDIV_LEVELS + 6;

    localparam logic [RW-1:0] RADIUS_RESET = RW'(256);
    localparam logic [MW-1:0] M_MAX        = MW'(65535);

    localparam logic [1:0] CHILD_CORNER0 = 2'd0;
    localparam logic [1:0] CHILD_CORNER1 = 2'd1;
    localparam logic [1:0] CHILD_CORNER2 = 2'd2;
    localparam logic [1:0] CHILD_MIDDLE  = 2'd3;

    typedef logic [2:0] t_corner_tab [3 * NUM_CUBE_TRIS];

    localparam t_corner_tab CUBE_TRIS = '{
        3'd0, 3'd1, 3'd2, 3'd1, 3'd3, 3'd2,
        3'd5, 3'd4, 3'd6, 3'd5, 3'd6, 3'd7,
        3'd0, 3'd2, 3'd4, 3'd4, 3'd2, 3'd6,
        3'd1, 3'd5, 3'd3, 3'd3, 3'd5, 3'd7,
        3'd2, 3'd3, 3'd6, 3'd3, 3'd7, 3'd6,
        3'd0, 3'd4, 3'd1, 3'd1, 3'd4, 3'd5
    };

    typedef logic [GW-1:0] t_inv_tab [2**NW];

    typedef struct packed {
        logic          oor;
        logic [FW-1:0] first_index;
    } t_tag;

    // Largest g with g*g*n <= 2^(2*GFRAC), i.e. floor(2^GFRAC / sqrt(n))
    function automatic t_inv_tab f_build_inv();
        t_inv_tab    tab;
        logic [63:0] g;
        logic [63:0] c;
        logic [63:0] lim;
        lim = 64'd1 << (2 * GFRAC);
        for (int n = 0; n < 2**NW; n++) begin
            g = '0;
            if (n != 0) begin
                for (int b = GW - 1; b >= 0; b--) begin
                    c = g | (64'd1 << b);
                    if (c * c * 64'(n) <= lim) begin
                        g = c;
                    end
                end
            end
            tab[n] = GW'(g);
        end
        return tab;
    endfunction

    localparam t_inv_tab INV_TAB = f_build_inv();

endpackage

`default_nettype wire

[rtl/cube_sphere_tessellator.sv]
// Cube-sphere tessellator. Each start gives one triangle of a twice-subdivided cube
// projected onto a sphere of the programmed radius (units of 1/256). A new triangle
// is taken every clock cycle (o_busy stays low); its result appears with o_done
// once it has passed one corner lookup stage, one stage per
// subdivision level, then five stages of normalisation (1/sqrt table, radius
// scaling, rounding estimate, exact square check, correction). The receiver cannot
// stall, so o_done results must be taken as they come. Write the radius only
// while no triangle is in flight.
`default_nettype none

module cube_sphere_tessellator
    import cst_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    output logic                 o_busy,
    input  wire  [TRI_W-1:0]     i_tri_number,
    input  wire                  i_cfg_we,
    input  wire  [RW-1:0]        i_cfg_wdata,
    output logic                 o_done,
    output logic signed [OW-1:0] o_ax,
    output logic signed [OW-1:0] o_ay,
    output logic signed [OW-1:0] o_az,
    output logic signed [OW-1:0] o_bx,
    output logic signed [OW-1:0] o_by,
    output logic signed [OW-1:0] o_bz,
    output logic signed [OW-1:0] o_cx,
    output logic signed [OW-1:0] o_cy,
    output logic signed [OW-1:0] o_cz,
    output logic [FW-1:0]        o_first_index
);

    function automatic logic signed [CW-1:0] f_corner_coord(logic [2:0] c, int k);
        logic pos;
        pos = (k == 2) ? !c[2] : c[k];
        return pos ? CW'(SCALE) : -CW'(SCALE);
    endfunction

    function automatic logic signed [CW-1:0] f_mid(logic signed [CW-1:0] a,
                                                   logic signed [CW-1:0] b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        return s[CW:1];
    endfunction

    logic [RW-1:0] r_radius;
    logic          r_vld [LAT];
    t_tag          r_tag [LAT];
    logic          accept;

    logic signed [CW-1:0] r_v   [SUBDIV_LEVELS+1][3][3];
    logic [TRI_W-1:0]     r_tri [SUBDIV_LEVELS+1];

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    // valid and tag travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= accept;
            for (int s = 1; s < LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0].oor         <= (i_tri_number >> (2 * SUBDIV_LEVELS)) >= NUM_CUBE_TRIS;
        r_tag[0].first_index <= FW'(3 * 32'(i_tri_number));
        for (int s = 1; s < LAT; s++) begin
            r_tag[s] <= r_tag[s-1];
        end
    end

    // corner lookup stage
    logic [CUBE_W-1:0] cube_sel;
    always_comb begin
        cube_sel = i_tri_number[TRI_W-1 -: CUBE_W];
        if (cube_sel >= CUBE_W'(NUM_CUBE_TRIS)) begin
            cube_sel = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tri[0] <= i_tri_number;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                r_v[0][i][k] <= f_corner_coord(CUBE_TRIS[3 * cube_sel + i], k);
            end
        end
    end

    // one register stage per subdivision level
    for (genvar l = 0; l < SUBDIV_LEVELS; l++) begin : g_level
        logic [1:0]           digit;
        logic signed [CW-1:0] m01 [3];
        logic signed [CW-1:0] m12 [3];
        logic signed [CW-1:0] m20 [3];
        logic signed [CW-1:0] nv  [3][3];

        assign digit = r_tri[l][2 * (SUBDIV_LEVELS - 1 - l) +: 2];

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                m01[k] = f_mid(r_v[l][0][k], r_v[l][1][k]);
                m12[k] = f_mid(r_v[l][1][k], r_v[l][2][k]);
                m20[k] = f_mid(r_v[l][2][k], r_v[l][0][k]);
            end
            for (int k = 0; k < 3; k++) begin
                case (digit)
                    CHILD_CORNER0: begin
                        nv[0][k] = r_v[l][0][k]; nv[1][k] = m01[k]; nv[2][k] = m20[k];
                    end
                    CHILD_CORNER1: begin
                        nv[0][k] = r_v[l][1][k]; nv[1][k] = m12[k]; nv[2][k] = m01[k];
                    end
                    CHILD_CORNER2: begin
                        nv[0][k] = r_v[l][2][k]; nv[1][k] = m20[k]; nv[2][k] = m12[k];
                    end
                    default: begin
                        nv[0][k] = m01[k]; nv[1][k] = m12[k]; nv[2][k] = m20[k];
                    end
                endcase
            end
        end

        always_ff @(posedge i_clk) begin
            r_tri[l+1] <= r_tri[l];
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_v[l+1][i][k] <= nv[i][k];
                end
            end
        end
    end

    // stage A: magnitudes, squared length, 1/sqrt lookup
    logic [AW-1:0] r_a_abs [9];
    logic          r_a_neg [9];
    logic [NW-1:0] r_a_n   [3];
    logic [GW-1:0] r_a_g   [3];
    logic [AW-1:0] a_abs   [9];
    logic [NW-1:0] a_n     [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                a_abs[3*i+k] = r_v[SUBDIV_LEVELS][i][k][CW-1]
                             ? AW'(-r_v[SUBDIV_LEVELS][i][k])
                             : AW'(r_v[SUBDIV_LEVELS][i][k]);
            end
            a_n[i] = NW'(NW'(a_abs[3*i]) * NW'(a_abs[3*i])
                       + NW'(a_abs[3*i+1]) * NW'(a_abs[3*i+1])
                       + NW'(a_abs[3*i+2]) * NW'(a_abs[3*i+2]));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 9; j++) begin
            r_a_abs[j] <= a_abs[j];
            r_a_neg[j] <= r_v[SUBDIV_LEVELS][j/3][j%3][CW-1];
        end
        for (int i = 0; i < 3; i++) begin
            r_a_n[i] <= a_n[i];
            r_a_g[i] <= INV_TAB[a_n[i]];
        end
    end

    // stage B: radius times 1/sqrt(n), radius squared
    logic [AW-1:0]  r_b_abs [9];
    logic           r_b_neg [9];
    logic [NW-1:0]  r_b_n   [3];
    logic [PW-1:0]  r_b_p   [3];
    logic [R2W-1:0] r_b_r2;

    always_ff @(posedge i_clk) begin
        r_b_abs <= r_a_abs;
        r_b_neg <= r_a_neg;
        r_b_n   <= r_a_n;
        for (int i = 0; i < 3; i++) begin
            r_b_p[i] <= PW'(r_radius) * PW'(r_a_g[i]);
        end
        r_b_r2 <= R2W'(r_radius) * R2W'(r_radius);
    end

    // stage C: rounded estimate and exact limit 4*r^2*x^2
    logic [MW-1:0] r_c_m0  [9];
    logic [LW-1:0] r_c_lim [9];
    logic          r_c_neg [9];
    logic [NW-1:0] r_c_n   [3];
    logic [TW-1:0] c_t     [9];

    always_comb begin
        for (int j = 0; j < 9; j++) begin
            c_t[j] = TW'(r_b_p[j/3]) * TW'(r_b_abs[j]) + (TW'(1) << (GFRAC - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_neg <= r_b_neg;
        r_c_n   <= r_b_n;
        for (int j = 0; j < 9; j++) begin
            r_c_m0[j]  <= c_t[j][GFRAC +: MW];
            r_c_lim[j] <= (LW'(r_b_r2) * LW'(LW'(r_b_abs[j]) * LW'(r_b_abs[j]))) << 2;
        end
    end

    // stage D: squares of 2m-1 and 2m+1
    logic [MW-1:0]  r_d_m0  [9];
    logic [LW-1:0]  r_d_lim [9];
    logic           r_d_neg [9];
    logic [NW-1:0]  r_d_n   [3];
    logic [SQW-1:0] r_d_lo  [9];
    logic [SQW-1:0] r_d_hi  [9];
    logic [MW:0]    d_lo    [9];
    logic [MW:0]    d_hi    [9];

    always_comb begin
        for (int j = 0; j < 9; j++) begin
            d_lo[j] = {r_c_m0[j], 1'b0} - (MW+1)'(1);
            d_hi[j] = {r_c_m0[j], 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_m0  <= r_c_m0;
        r_d_lim <= r_c_lim;
        r_d_neg <= r_c_neg;
        r_d_n   <= r_c_n;
        for (int j = 0; j < 9; j++) begin
            r_d_lo[j] <= SQW'(d_lo[j]) * SQW'(d_lo[j]);
            r_d_hi[j] <= SQW'(d_hi[j]) * SQW'(d_hi[j]);
        end
    end

    // stage E: step the estimate by one where the exact test says so, clamp, restore sign, zero out-of-range
    logic signed [OW-1:0] r_e_out [9];
    logic [MW-1:0]        e_m     [9];
    logic [CMPW-1:0]      e_lim   [9];

    always_comb begin
        for (int j = 0; j < 9; j++) begin
            e_lim[j] = CMPW'(r_d_lim[j]);
            e_m[j]   = r_d_m0[j];
            if (r_d_m0[j] != '0
                && CMPW'(r_d_lo[j]) * CMPW'(r_d_n[j/3]) > e_lim[j]) begin
                e_m[j] = r_d_m0[j] - MW'(1);
            end else if (CMPW'(r_d_hi[j]) * CMPW'(r_d_n[j/3]) <= e_lim[j]) begin
                e_m[j] = r_d_m0[j] + MW'(1);
            end
            if (e_m[j] > M_MAX) begin
                e_m[j] = M_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 9; j++) begin
            if (r_tag[LAT-2].oor) begin
                r_e_out[j] <= '0;
            end else if (r_d_neg[j]) begin
                r_e_out[j] <= -OW'(e_m[j]);
            end else begin
                r_e_out[j] <= OW'(e_m[j]);
            end
        end
    end

    assign o_done        = r_vld[LAT-1];
    assign o_first_index = r_tag[LAT-1].first_index;
    assign o_ax = r_e_out[0];
    assign o_ay = r_e_out[1];
    assign o_az = r_e_out[2];
    assign o_bx = r_e_out[3];
    assign o_by = r_e_out[4];
    assign o_bz = r_e_out[5];
    assign o_cx = r_e_out[6];
    assign o_cy = r_e_out[7];
    assign o_cz = r_e_out[8];

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, LAT))
        else $error("result without a matching start");

    a_first_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_first_index == FW'(3 * 32'($past(i_tri_number, LAT))))
        else $error("first index does not match triangle number");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_tag[LAT-1].oor) |-> (o_ax == '0 && o_by == '0 && o_cz == '0))
        else $error("out-of-range cube triangle gave non-zero vertex");

    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_radius == '0) |-> (o_ax == '0 && o_bx == '0 && o_cx == '0))
        else $error("zero radius gave non-zero vertex");

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import cst_pkg::*;

    typedef struct {
        logic [OW-1:0] coord [9];
        logic [FW-1:0] first_index;
    } t_tri_verts;

    localparam int DRAIN_CYCLES = LAT + 4;
    localparam int CYCLE_LIMIT  = 200000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic [TRI_W-1:0] i_tri_number;
    logic             i_cfg_we;
    logic [RW-1:0]    i_cfg_wdata;
    logic             o_busy;
    logic             o_done;
    logic signed [OW-1:0] o_ax, o_ay, o_az, o_bx, o_by, o_bz, o_cx, o_cy, o_cz;
    logic [FW-1:0]    o_first_index;

    t_tri_verts    pending_verts [$];
    logic [RW-1:0] radius_model;
    int            mismatches;
    int            cycles;
    int            idle_pct;

    const string coord_name [9] = '{"ax", "ay", "az", "bx", "by", "bz", "cx", "cy", "cz"};
    const logic [2:0] corner_table [36] = '{
        3'd0, 3'd1, 3'd2, 3'd1, 3'd3, 3'd2,
        3'd5, 3'd4, 3'd6, 3'd5, 3'd6, 3'd7,
        3'd0, 3'd2, 3'd4, 3'd4, 3'd2, 3'd6,
        3'd1, 3'd5, 3'd3, 3'd3, 3'd5, 3'd7,
        3'd2, 3'd3, 3'd6, 3'd3, 3'd7, 3'd6,
        3'd0, 3'd4, 3'd1, 3'd1, 3'd4, 3'd5
    };

    cube_sphere_tessellator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_tri_number  (i_tri_number),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_done        (o_done),
        .o_ax          (o_ax),
        .o_ay          (o_ay),
        .o_az          (o_az),
        .o_bx          (o_bx),
        .o_by          (o_by),
        .o_bz          (o_bz),
        .o_cx          (o_cx),
        .o_cy          (o_cy),
        .o_cz          (o_cz),
        .o_first_index (o_first_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Round |r*x/sqrt(n)| to nearest, ties away from zero, by bitwise search
    function automatic logic [OW-1:0] sphere_coord(int x, longint unsigned n,
                                                  longint unsigned r);
        longint unsigned ax;
        longint unsigned lim;
        longint unsigned m;
        longint unsigned c;
        longint unsigned d;
        ax  = (x < 0) ? longint'(-x) : longint'(x);
        lim = 4 * r * r * ax * ax;
        m   = 0;
        if (n == 0) begin
            return '0;
        end
        for (int b = 16; b >= 0; b--) begin
            c = m | (64'd1 << b);
            d = 2 * c - 1;
            if (d * d * n <= lim) begin
                m = c;
            end
        end
        if (m > 65535) begin
            m = 65535;
        end
        return (x < 0) ? OW'(-m) : OW'(m);
    endfunction

    function automatic t_tri_verts tessellate(logic [TRI_W-1:0] tri_num, logic [RW-1:0] r);
        t_tri_verts      res;
        int              v [3][3];
        int              nv [3][3];
        int              mids [3][3];
        int              cube;
        int              digit;
        int              cn;
        longint unsigned n;
        res.first_index = FW'(3 * int'(tri_num));
        cube = int'(tri_num) >> (2 * SUBDIV_LEVELS);
        foreach (res.coord[k]) res.coord[k] = '0;
        if (cube >= NUM_CUBE_TRIS) begin
            return res;
        end
        for (int i = 0; i < 3; i++) begin
            cn = corner_table[cube * 3 + i];
            v[i][0] = cn[0] ? SCALE : -SCALE;
            v[i][1] = cn[1] ? SCALE : -SCALE;
            v[i][2] = cn[2] ? -SCALE : SCALE;
        end
        for (int lvl = 0; lvl < SUBDIV_LEVELS; lvl++) begin
            digit = (int'(tri_num) >> (2 * (SUBDIV_LEVELS - 1 - lvl))) & 3;
            // mids: m01, m12, m20
            for (int k = 0; k < 3; k++) begin
                mids[0][k] = (v[0][k] + v[1][k]) / 2;
                mids[1][k] = (v[1][k] + v[2][k]) / 2;
                mids[2][k] = (v[2][k] + v[0][k]) / 2;
            end
            for (int k = 0; k < 3; k++) begin
                case (digit)
                    CHILD_CORNER0: begin
                        nv[0][k] = v[0][k]; nv[1][k] = mids[0][k]; nv[2][k] = mids[2][k];
                    end
                    CHILD_CORNER1: begin
                        nv[0][k] = v[1][k]; nv[1][k] = mids[1][k]; nv[2][k] = mids[0][k];
                    end
                    CHILD_CORNER2: begin
                        nv[0][k] = v[2][k]; nv[1][k] = mids[2][k]; nv[2][k] = mids[1][k];
                    end
                    default: begin
                        nv[0][k] = mids[0][k]; nv[1][k] = mids[1][k]; nv[2][k] = mids[2][k];
                    end
                endcase
            end
            v = nv;
        end
        for (int i = 0; i < 3; i++) begin
            n = 0;
            for (int k = 0; k < 3; k++) n += longint'(v[i][k] * v[i][k]);
            for (int k = 0; k < 3; k++) res.coord[i * 3 + k] = sphere_coord(v[i][k], n, r);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Results cannot be held off: sample mid-cycle, away from the driving edge
    always @(negedge i_clk) begin
        t_tri_verts        exp_v;
        logic [OW-1:0]     got [9];
        if (i_rst_n && o_done) begin
            got = '{o_ax, o_ay, o_az, o_bx, o_by, o_bz, o_cx, o_cy, o_cz};
            if (pending_verts.size() == 0) begin
                $error("unexpected transaction: first_index %0d", o_first_index);
                mismatches++;
            end else begin
                exp_v = pending_verts.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (got[k] !== exp_v.coord[k]) begin
                        $error("%s: expected %0d, got %0d", coord_name[k],
                               $signed(exp_v.coord[k]), $signed(got[k]));
                        mismatches++;
                    end
                end
                if (o_first_index !== exp_v.first_index) begin
                    $error("first_index: expected %0d, got %0d",
                           exp_v.first_index, o_first_index);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_tri(logic [TRI_W-1:0] tri_num);
        bit taken;
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_tri_number <= tri_num;
        forever begin
            @(negedge i_clk);
            taken = !o_busy;
            @(posedge i_clk);
            if (taken) break;
        end
        pending_verts.push_back(tessellate(tri_num, radius_model));
    endtask

    // Drop start, wait for all transactions to land, then let the pipe empty
    task automatic drain_pipe();
        i_start <= 1'b0;
        while (pending_verts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_radius(logic [RW-1:0] r);
        drain_pipe();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= r;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        radius_model = r;
    endtask

    task automatic test_directed();
        logic [TRI_W-1:0] picks [14] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd8, 8'd12,
                                         8'd15, 8'd127, 8'd128, 8'd191, 8'd192,
                                         8'd255, 8'd85};
        idle_pct = 0;
        foreach (picks[i]) send_tri(picks[i]);
        set_radius(16'd65535);
        foreach (picks[i]) if (i < 6) send_tri(picks[i] ^ 8'hAA);
        set_radius(16'd0);
        send_tri(8'd5);
        send_tri(8'd170);
        set_radius(16'd1);
        send_tri(8'd3);
        send_tri(8'd60);
    endtask

    task automatic test_random(int count, int pct, logic [RW-1:0] r);
        logic [TRI_W-1:0] t;
        set_radius(r);
        idle_pct = pct;
        for (int i = 0; i < count; i++) begin
            // mostly valid cube triangles, some out of range
            if ($urandom_range(9) == 0) t = TRI_W'($urandom_range(255, 192));
            else                        t = TRI_W'($urandom_range(191));
            send_tri(t);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_tri_number = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        mismatches   = 0;
        cycles       = 0;
        idle_pct     = 0;
        radius_model = RADIUS_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(300, 0, RW'($urandom));
        test_random(300, 66, 16'hFFFF);
        test_random(300, 0, RW'($urandom_range(1023)));
        test_random(300, 21, 16'h5A5A);

        drain_pipe();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
rtl/cst_pkg.sv
rtl/cube_sphere_tessellator.sv
dv/tb_top.sv
